// ===== rtl/core/spsb_pkg.sv =====
// Shared types, widths and codes for the stroke point smoother with bounding box.
`default_nettype none

package spsb_pkg;

  localparam int COORD_W          = 24;
  localparam int PRESS_W          = 9;
  localparam int CFG_W            = 8;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int WINDOW_DEPTH_DEF = 8;

  localparam logic REG_BOX_PADDING  = 1'b0;
  localparam logic REG_STROKE_WIDTH = 1'b1;

  localparam logic [CFG_W-1:0] BOX_PADDING_RST  = 8'd0;
  localparam logic [CFG_W-1:0] STROKE_WIDTH_RST = 8'd1;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_DIV,
    ST_BOX,
    ST_EMIT
  } spsb_state_e;

  typedef struct packed {
    logic start;
    logic done;
    logic busy;
  } spsb_div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spsb_in_if.sv =====
// Handshake channel that carries one pen sample word into the block.
`default_nettype none

interface spsb_in_if
  import spsb_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [PRESS_W-1:0]        pressure_in;
  logic                      smooth_enable;
  logic                      stroke_start;

  modport source (
    output valid, point_x, point_y, pressure_in, smooth_enable, stroke_start,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, pressure_in, smooth_enable, stroke_start,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/spsb_out_if.sv =====
// Handshake channel that carries one stored point and bounding box word out of the block.
`default_nettype none

interface spsb_out_if
  import spsb_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [PRESS_W-1:0]        pressure_out;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic signed [COORD_W-1:0] box_right;
  logic signed [COORD_W-1:0] box_bottom;

  modport source (
    output valid, out_x, out_y, pressure_out, box_left, box_top, box_right, box_bottom,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, pressure_out, box_left, box_top, box_right, box_bottom,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/spsb_div.sv =====
// Bit-serial signed by unsigned divider with truncation toward zero.
`default_nettype none

module spsb_div
  import spsb_pkg::*;
#(
  parameter int DVD_W = 27,
  parameter int DVS_W = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0]        divisor_i,
  output spsb_div_ctrl_t               ctrl_o,
  output logic signed [DVD_W-1:0]      quotient_o
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DVD_W-1];
      cnt_d  = '0;
      quo_d  = dividend_i[DVD_W-1] ? (DVD_W'(0) - dividend_i) : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o   = neg_q ? $signed(DVD_W'(0) - quo_q) : $signed(quo_q);
  assign ctrl_o.start = start_i;
  assign ctrl_o.done  = done_q;
  assign ctrl_o.busy  = busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/stroke_point_smoother_bbox.sv =====
// Top level of the pen stroke point smoother with moving average window and bounding box.
//
//   Channel   Direction  Word
//   sample_i  in         point_x, point_y, pressure_in, smooth_enable, stroke_start
//   result_o  out        out_x, out_y, pressure_out, box_left, box_top, box_right, box_bottom
//   APB       in/out     box_padding at 0x0, stroke_width at 0x4
//
// A smoothed sample runs the read, accumulate, divide, box and emit steps; divide waits for
// the bit-serial divider that forms sum over fill count. A raw sample runs box and emit only.
// One sample is in work at a time; the output register holds a finished word while the next
// sample is accepted. Reset clears the window count, sums and box at once, with no clearing pass.
// A stalled output holds the block in its emit step until the waiting word is taken.
`default_nettype none

module stroke_point_smoother_bbox
  import spsb_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  spsb_in_if.sink                    sample_i,
  spsb_out_if.source                 result_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int SUM_W  = COORD_W + $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int EXT_W  = COORD_W + 2;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(WINDOW_DEPTH - 1);

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v < EXT_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else if (v > EXT_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  spsb_state_e state_q, state_d;

  logic [CFG_W-1:0] box_padding_q, stroke_width_q;
  logic             cfg_we;

  logic signed [SUM_W-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [IDX_W-1:0]          head_q, head_d;
  logic                      have_q, have_d;
  logic signed [COORD_W-1:0] edge_l_q, edge_l_d, edge_t_q, edge_t_d;
  logic signed [COORD_W-1:0] edge_r_q, edge_r_d, edge_b_q, edge_b_d;

  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic [PRESS_W-1:0]        press_q, press_d;
  logic                      smooth_q, smooth_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [PRESS_W-1:0]        opress_q, opress_d;
  logic signed [COORD_W-1:0] ol_q, ol_d, ot_q, ot_d, or_q, or_d, ob_q, ob_d;

  logic [2*COORD_W-1:0]      win_mem [WINDOW_DEPTH];
  logic [2*COORD_W-1:0]      rd_q;
  logic                      win_we;
  logic signed [COORD_W-1:0] old_x, old_y;
  logic                      full;

  logic                      div_start;
  spsb_div_ctrl_t            div_x_ctrl, div_y_ctrl;
  logic signed [SUM_W-1:0]   quo_x, quo_y;

  logic [CFG_W:0]            margin;
  logic signed [EXT_W-1:0]   margin_ext, x_ext, y_ext;
  logic signed [COORD_W-1:0] cand_l, cand_t, cand_r, cand_b;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_padding_q  <= BOX_PADDING_RST;
      stroke_width_q <= STROKE_WIDTH_RST;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_BOX_PADDING:  box_padding_q  <= pwdata[CFG_W-1:0];
        REG_STROKE_WIDTH: stroke_width_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BOX_PADDING:  prdata = APB_DATA_W'(box_padding_q);
      REG_STROKE_WIDTH: prdata = APB_DATA_W'(stroke_width_q);
      default:          prdata = '0;
    endcase
  end

  // Window memory.
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[head_q] <= {px_q, py_q};
    end
    rd_q <= win_mem[head_q];
  end

  assign old_x = rd_q[2*COORD_W-1:COORD_W];
  assign old_y = rd_q[COORD_W-1:0];
  assign full  = (fill_q == FILL_MAX);

  spsb_div #(
    .DVD_W (SUM_W),
    .DVS_W (FILL_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_x_d),
    .divisor_i  (fill_d),
    .ctrl_o     (div_x_ctrl),
    .quotient_o (quo_x)
  );

  spsb_div #(
    .DVD_W (SUM_W),
    .DVS_W (FILL_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_y_d),
    .divisor_i  (fill_d),
    .ctrl_o     (div_y_ctrl),
    .quotient_o (quo_y)
  );

  // Box candidates for the current point.
  assign margin     = {1'b0, box_padding_q} + {1'b0, stroke_width_q};
  assign margin_ext = $signed(EXT_W'({margin, 8'h00}));
  assign x_ext      = EXT_W'(px_q);
  assign y_ext      = EXT_W'(py_q);
  assign cand_l     = sat_coord(x_ext - margin_ext);
  assign cand_t     = sat_coord(y_ext - margin_ext);
  assign cand_r     = sat_coord(x_ext + margin_ext);
  assign cand_b     = sat_coord(y_ext + margin_ext);

  assign sample_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    fill_d      = fill_q;
    head_d      = head_q;
    have_d      = have_q;
    edge_l_d    = edge_l_q;
    edge_t_d    = edge_t_q;
    edge_r_d    = edge_r_q;
    edge_b_d    = edge_b_q;
    px_d        = px_q;
    py_d        = py_q;
    press_d     = press_q;
    smooth_d    = smooth_q;
    out_valid_d = out_valid_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    opress_d    = opress_q;
    ol_d        = ol_q;
    ot_d        = ot_q;
    or_d        = or_q;
    ob_d        = ob_q;
    win_we      = 1'b0;
    div_start   = 1'b0;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          px_d     = sample_i.point_x;
          py_d     = sample_i.point_y;
          press_d  = sample_i.pressure_in;
          smooth_d = sample_i.smooth_enable;
          if (sample_i.stroke_start) begin
            sum_x_d = '0;
            sum_y_d = '0;
            fill_d  = '0;
            head_d  = '0;
            have_d  = 1'b0;
          end
          state_d = sample_i.smooth_enable ? ST_READ : ST_BOX;
        end
      end
      ST_READ: begin
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        win_we    = 1'b1;
        div_start = 1'b1;
        if (full) begin
          sum_x_d = sum_x_q - SUM_W'(old_x) + SUM_W'(px_q);
          sum_y_d = sum_y_q - SUM_W'(old_y) + SUM_W'(py_q);
        end else begin
          sum_x_d = sum_x_q + SUM_W'(px_q);
          sum_y_d = sum_y_q + SUM_W'(py_q);
          fill_d  = fill_q + 1'b1;
        end
        head_d  = (head_q == IDX_MAX) ? '0 : head_q + 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_x_ctrl.done) begin
          px_d    = quo_x[COORD_W-1:0];
          py_d    = quo_y[COORD_W-1:0];
          state_d = ST_BOX;
        end
      end
      ST_BOX: begin
        have_d = 1'b1;
        if (!have_q || (cand_l < edge_l_q)) edge_l_d = cand_l;
        if (!have_q || (cand_t < edge_t_q)) edge_t_d = cand_t;
        if (!have_q || (cand_r > edge_r_q)) edge_r_d = cand_r;
        if (!have_q || (cand_b > edge_b_q)) edge_b_d = cand_b;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          ox_d        = px_q;
          oy_d        = py_q;
          opress_d    = press_q;
          ol_d        = edge_l_q;
          ot_d        = edge_t_q;
          or_d        = edge_r_q;
          ob_d        = edge_b_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      have_q      <= 1'b0;
      edge_l_q    <= '0;
      edge_t_q    <= '0;
      edge_r_q    <= '0;
      edge_b_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      have_q      <= have_d;
      edge_l_q    <= edge_l_d;
      edge_t_q    <= edge_t_d;
      edge_r_q    <= edge_r_d;
      edge_b_q    <= edge_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    press_q  <= press_d;
    smooth_q <= smooth_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    opress_q <= opress_d;
    ol_q     <= ol_d;
    ot_q     <= ot_d;
    or_q     <= or_d;
    ob_q     <= ob_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_x        = ox_q;
  assign result_o.out_y        = oy_q;
  assign result_o.pressure_out = opress_q;
  assign result_o.box_left     = ol_q;
  assign result_o.box_top      = ot_q;
  assign result_o.box_right    = or_q;
  assign result_o.box_bottom   = ob_q;

  // Checks.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill count exceeds the window depth");

  a_div_only_when_smoothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_x_ctrl.busy || div_x_ctrl.done) |-> (state_q == ST_DIV && smooth_q))
    else $error("divider active outside a smoothed sample");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_x_ctrl.done == div_y_ctrl.done) && (div_x_ctrl.busy == div_y_ctrl.busy))
    else $error("x and y dividers out of step");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (edge_l_q <= edge_r_q && edge_t_q <= edge_b_q))
    else $error("bounding box edges crossed");

  a_emit_after_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BOX) |=> (state_q == ST_EMIT && have_q))
    else $error("box step not followed by emit with a live box");

endmodule

`default_nettype wire
